### hw/rtl/xrng_pkg.sv
package xrng_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;
    localparam int unsigned SEED_W = 31;
    localparam int unsigned OP_W   = 2;

    localparam logic [OP_W-1:0] OP_DRAW = 2'd0;
    localparam logic [OP_W-1:0] OP_SEED = 2'd1;
    localparam logic [OP_W-1:0] OP_JUMP = 2'd2;

    localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL2  = 64'h94D0_49BB_1331_11EB;

    localparam logic [2*WORD_W-1:0] JUMP_POLY =
        128'hd86b_048b_86aa_9922_beac_0467_eba5_facb;

    localparam int unsigned ROT_A   = 55;
    localparam int unsigned SHIFT_B = 14;
    localparam int unsigned ROT_C   = 36;
    localparam int unsigned MIX_S1  = 30;
    localparam int unsigned MIX_S2  = 27;
    localparam int unsigned MIX_S3  = 31;

    localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

    typedef struct packed {
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } t_state;

    function automatic t_state xr_advance(input t_state s);
        logic [WORD_W-1:0] t;
        t_state            r;
        t    = s.lo ^ s.hi;
        r.lo = ((s.lo << ROT_A) | (s.lo >> (WORD_W - ROT_A))) ^ t ^ (t << SHIFT_B);
        r.hi = (t << ROT_C) | (t >> (WORD_W - ROT_C));
        return r;
    endfunction

endpackage

### hw/rtl/xoroshiro128plus_rng.sv
// Draw: result registered in the cycle after the request; one draw per cycle sustained while i_stall is low.
// Seed: three splitmix64 words, each through two 64-bit products
// formed as three 32x32 partial products on one shared multiplier.
// Jump: one state step per polynomial bit on the shared step unit.
// Reset (synchronous, active low) starts a seed with value 1; o_stall is high
// until that seed completes.
module xoroshiro128plus_rng
    import xrng_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [SEED_W-1:0]   i_seed_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [WORD_W-1:0]   o_random_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX_START,
        S_MUL,
        S_MUL_DONE,
        S_JUMP
    } t_fsm;

    t_fsm              r_st, n_st;
    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_ctr, n_ctr;
    logic [WORD_W-1:0] r_z, n_z;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic              r_mul_sel, n_mul_sel;
    logic [1:0]        r_pp, n_pp;
    logic [1:0]        r_word, n_word;
    logic [6:0]        r_jcnt, n_jcnt;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;

    t_state            adv;
    logic [WORD_W-1:0] mul_c;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] ctr_inc;
    logic [WORD_W-1:0] mix_out;
    logic              accept;
    logic              out_take;
    logic              jbit;

    assign adv      = xr_advance(r_state);
    assign o_stall  = (r_st != S_IDLE) || (r_out_valid && i_stall);
    assign accept   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    assign mul_c = r_mul_sel ? MIX_MUL2 : MIX_MUL1;
    assign mul_a = (r_pp == 2'd2) ? r_z[WORD_W-1:HALF_W] : r_z[HALF_W-1:0];
    assign mul_b = (r_pp == 2'd1) ? mul_c[WORD_W-1:HALF_W] : mul_c[HALF_W-1:0];
    assign prod  = mul_a * mul_b;

    assign ctr_inc = r_ctr + MIX_GAMMA;
    assign mix_out = r_acc ^ (r_acc >> MIX_S3);
    assign jbit    = JUMP_POLY[r_jcnt];

    always_comb begin
        n_st        = r_st;
        n_state     = r_state;
        n_ctr       = r_ctr;
        n_z         = r_z;
        n_acc       = r_acc;
        n_mul_sel   = r_mul_sel;
        n_pp        = r_pp;
        n_word      = r_word;
        n_jcnt      = r_jcnt;
        n_out_valid = r_out_valid && !out_take;
        n_out_word  = r_out_word;

        unique case (r_st)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_DRAW: begin
                            n_out_valid = 1'b1;
                            n_out_word  = r_state.lo + r_state.hi;
                            n_state     = adv;
                        end
                        OP_SEED: begin
                            n_ctr  = {{(WORD_W - SEED_W){1'b0}}, i_seed_value};
                            n_word = 2'd0;
                            n_st   = S_MIX_START;
                        end
                        OP_JUMP: begin
                            n_acc  = '0;
                            n_z    = '0;
                            n_jcnt = '0;
                            n_st   = S_JUMP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MIX_START: begin
                n_ctr     = ctr_inc;
                n_z       = ctr_inc ^ (ctr_inc >> MIX_S1);
                n_mul_sel = 1'b0;
                n_pp      = 2'd0;
                n_st      = S_MUL;
            end
            S_MUL: begin
                if (r_pp == 2'd0) begin
                    n_acc = prod;
                end else begin
                    n_acc = r_acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                end
                if (r_pp == 2'd2) begin
                    n_st = S_MUL_DONE;
                end else begin
                    n_pp = r_pp + 2'd1;
                end
            end
            S_MUL_DONE: begin
                if (!r_mul_sel) begin
                    n_z       = r_acc ^ (r_acc >> MIX_S2);
                    n_mul_sel = 1'b1;
                    n_pp      = 2'd0;
                    n_st      = S_MUL;
                end else begin
                    if (r_word == 2'd1) begin
                        n_state.lo = mix_out;
                    end
                    if (r_word == 2'd2) begin
                        n_state.hi = mix_out;
                        n_st       = S_IDLE;
                    end else begin
                        n_word = r_word + 2'd1;
                        n_st   = S_MIX_START;
                    end
                end
            end
            S_JUMP: begin
                if (jbit) begin
                    n_acc = r_acc ^ r_state.lo;
                    n_z   = r_z ^ r_state.hi;
                end
                if (r_jcnt == 7'h7F) begin
                    n_state.lo = n_acc;
                    n_state.hi = n_z;
                    n_st       = S_IDLE;
                end else begin
                    n_state = adv;
                    n_jcnt  = r_jcnt + 7'd1;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_MIX_START;
            r_ctr       <= SEED_RESET;
            r_word      <= 2'd0;
            r_mul_sel   <= 1'b0;
            r_pp        <= 2'd0;
            r_jcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_ctr       <= n_ctr;
            r_word      <= n_word;
            r_mul_sel   <= n_mul_sel;
            r_pp        <= n_pp;
            r_jcnt      <= n_jcnt;
            r_out_valid <= n_out_valid;
        end
        r_state    <= n_state;
        r_z        <= n_z;
        r_acc      <= n_acc;
        r_out_word <= n_out_word;
    end

    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_DRAW) |=> o_valid)
        else $error("draw request gave no result");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE && !o_valid) |=> !o_valid)
        else $error("result appeared during seed or jump");

    a_pp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MUL) |-> (r_pp != 2'd3))
        else $error("partial product index out of range");

    a_jump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_JUMP && r_jcnt == 7'h7F) |=> (r_st == S_IDLE))
        else $error("jump did not finish after last bit");

endmodule
